FILE: src/gpioei_pkg.sv
// Package with the command and register codes shared by the GPIO block files.
`timescale 1ns / 1ps

package gpioei_pkg;

    // Width of a bus data word and of a pin-level word on the stream ports.
    localparam int DATA_W = 32;

    // Widths of the control fields carried in the input tuser.
    localparam int CMD_W  = 2;
    localparam int PORT_W = 3;
    localparam int REG_W  = 4;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    // Register select codes.
    localparam logic [REG_W-1:0] REG_DIR       = 4'd0;
    localparam logic [REG_W-1:0] REG_SET       = 4'd1;
    localparam logic [REG_W-1:0] REG_CLR       = 4'd2;
    localparam logic [REG_W-1:0] REG_PIN       = 4'd3;
    localparam logic [REG_W-1:0] REG_RISE_EN   = 4'd4;
    localparam logic [REG_W-1:0] REG_FALL_EN   = 4'd5;
    localparam logic [REG_W-1:0] REG_RISE_STAT = 4'd6;
    localparam logic [REG_W-1:0] REG_FALL_STAT = 4'd7;
    localparam logic [REG_W-1:0] REG_INT_CLR   = 4'd8;
    localparam logic [REG_W-1:0] REG_SUMMARY   = 4'd9;

    // Ports that carry edge-detect logic, and their slot indexes.
    localparam logic [PORT_W-1:0] EDGE_PORT_A = 3'd0;
    localparam logic [PORT_W-1:0] EDGE_PORT_B = 3'd2;
    localparam int NUM_SLOTS = 2;

    // Update strobes for the edge-detect registers, already qualified by the
    // pipeline advancing.
    typedef struct packed {
        logic wr_rise_en;
        logic wr_fall_en;
        logic int_clr;
        logic sample;
        logic slot;
    } t_edge_ctl;

endpackage

FILE: src/gpio_port_with_edge_interrupts.sv
// Top level of the GPIO block: access pipeline, port state memory and edge logic.
`timescale 1ns / 1ps

// Channel   Dir  Group                 Contents
// input     in   s_axis_*  tdata 64    access or pin-sample beat
//                          tuser 9     cmd, port, reg_sel
// result    out  m_axis_*  tdata 40    read_data and irq
//
// One beat is taken per clock while the result is not stalled. A beat is accepted
// into the first stage, which issues the read of the port state memory; as the
// beat leaves that stage, the entry (or the value just written by the previous
// beat, forwarded) is modified and written back, and the result lands in the
// output register. The memory's single read and single write port set this rate.
// Reset clears the valid bits of the port memory and the edge registers at once,
// so beats are accepted from the first cycle after reset. A stalled result holds
// the output register; the first stage then holds its beat and read data too.

module gpio_port_with_edge_interrupts
    import gpioei_pkg::*;
#(
    parameter int NUM_PORTS  = 6,
    parameter int PORT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] write_data, [63:32] pin_levels
    input  logic [63:0] s_axis_tdata,
    // [1:0] cmd, [4:2] port, [8:5] reg_sel
    input  logic [8:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_data, [32] irq, [39:33] zero
    output logic [39:0] m_axis_tdata
);

    localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int PW = PORT_WIDTH;
    localparam int EW = 3 * PW;

    // Input beat fields.
    logic [CMD_W-1:0]  in_cmd;
    logic [PORT_W-1:0] in_port;
    logic [REG_W-1:0]  in_reg;
    logic              in_range;
    logic              in_acc;

    assign in_cmd   = s_axis_tuser[1:0];
    assign in_port  = s_axis_tuser[4:2];
    assign in_reg   = s_axis_tuser[8:5];
    assign in_range = {1'b0, in_port} < (PORT_W + 1)'(NUM_PORTS);
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    // First stage: the beat waiting for its memory read data.
    logic              r_s1_valid;
    logic [CMD_W-1:0]  r_s1_cmd;
    logic [PORT_W-1:0] r_s1_port;
    logic [REG_W-1:0]  r_s1_reg;
    logic [PW-1:0]     r_s1_wd;
    logic [PW-1:0]     r_s1_lv;
    logic              r_fwd_hit;
    logic [EW-1:0]     r_fwd_data;

    // Output register.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_rd;
    logic              r_out_irq;

    logic s1_adv;
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;

    // Port state memory.
    logic [EW-1:0] ram_rd_data;
    logic          ram_we;
    logic [AW-1:0] ram_wr_addr;
    logic [EW-1:0] ram_wr_data;

    gpioei_port_ram #(
        .DEPTH (NUM_PORTS),
        .AW    (AW),
        .DW    (EW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc && in_range),
        .i_rd_addr (in_port[AW-1:0]),
        .o_rd_data (ram_rd_data),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data)
    );

    // Current entry of the first-stage beat: the memory word, or the word the
    // previous beat wrote back in the same cycle the read was issued.
    logic [EW-1:0] s1_ent;
    logic [PW-1:0] cur_dir, cur_lat, cur_smp;
    logic [PW-1:0] n_dir, n_lat, n_smp;
    logic          s1_range;
    logic          s1_edge;

    assign s1_ent   = r_fwd_hit ? r_fwd_data : ram_rd_data;
    assign cur_dir  = s1_ent[PW-1:0];
    assign cur_lat  = s1_ent[2*PW-1:PW];
    assign cur_smp  = s1_ent[3*PW-1:2*PW];
    assign s1_range = {1'b0, r_s1_port} < (PORT_W + 1)'(NUM_PORTS);
    assign s1_edge  = (r_s1_port == EDGE_PORT_A) || (r_s1_port == EDGE_PORT_B);

    // Modified entry.
    always_comb begin
        n_dir = cur_dir;
        n_lat = cur_lat;
        n_smp = cur_smp;
        if (r_s1_cmd == CMD_WRITE) begin
            case (r_s1_reg)
                REG_DIR: n_dir = r_s1_wd;
                REG_SET: n_lat = cur_lat | r_s1_wd;
                REG_CLR: n_lat = cur_lat & ~r_s1_wd;
                REG_PIN: n_lat = r_s1_wd;
                default: ;
            endcase
        end else if (r_s1_cmd == CMD_SAMPLE) begin
            n_smp = r_s1_lv;
        end
    end

    assign ram_we      = s1_adv && s1_range &&
                         ((r_s1_cmd == CMD_WRITE) || (r_s1_cmd == CMD_SAMPLE));
    assign ram_wr_addr = r_s1_port[AW-1:0];
    assign ram_wr_data = {n_smp, n_lat, n_dir};

    // Edge-detect logic for ports 0 and 2.
    t_edge_ctl             edge_ctl;
    logic [PW-1:0]         e_rise_en, e_fall_en, e_rise_stat, e_fall_stat;
    logic [NUM_SLOTS-1:0]  e_pending;
    logic                  e_irq_next;
    logic                  s1_wr;

    assign s1_wr = s1_adv && s1_edge && (r_s1_cmd == CMD_WRITE);

    always_comb begin
        edge_ctl.wr_rise_en = s1_wr && (r_s1_reg == REG_RISE_EN);
        edge_ctl.wr_fall_en = s1_wr && (r_s1_reg == REG_FALL_EN);
        edge_ctl.int_clr    = s1_wr && (r_s1_reg == REG_INT_CLR);
        edge_ctl.sample     = s1_adv && s1_edge && (r_s1_cmd == CMD_SAMPLE);
        edge_ctl.slot       = (r_s1_port == EDGE_PORT_B);
    end

    gpioei_edge #(
        .PW (PW)
    ) u_edge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (edge_ctl),
        .i_wdata     (r_s1_wd),
        .i_old_lvl   (cur_smp),
        .i_new_lvl   (r_s1_lv),
        .o_rise_en   (e_rise_en),
        .o_fall_en   (e_fall_en),
        .o_rise_stat (e_rise_stat),
        .o_fall_stat (e_fall_stat),
        .o_pending   (e_pending),
        .o_irq_next  (e_irq_next)
    );

    // Read data. The summary register answers whatever the port number is.
    logic [DATA_W-1:0] s1_rd;
    logic [PW-1:0]     reg_val;

    always_comb begin
        reg_val = '0;
        case (r_s1_reg)
            REG_DIR:       reg_val = cur_dir;
            REG_SET:       reg_val = cur_lat;
            REG_PIN:       reg_val = (cur_lat & cur_dir) | (cur_smp & ~cur_dir);
            REG_RISE_EN:   reg_val = s1_edge ? e_rise_en : '0;
            REG_FALL_EN:   reg_val = s1_edge ? e_fall_en : '0;
            REG_RISE_STAT: reg_val = s1_edge ? e_rise_stat : '0;
            REG_FALL_STAT: reg_val = s1_edge ? e_fall_stat : '0;
            default:       reg_val = '0;
        endcase
        s1_rd = '0;
        if (r_s1_cmd == CMD_READ) begin
            if (r_s1_reg == REG_SUMMARY) begin
                s1_rd[0] = e_pending[0];
                s1_rd[2] = e_pending[1];
            end else if (s1_range) begin
                s1_rd = DATA_W'(reg_val);
            end
        end
    end

    // First-stage registers. The forward flag and word follow the beat, so
    // they stay put with it while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= ram_we && (ram_wr_addr == in_port[AW-1:0]);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd   <= in_cmd;
            r_s1_port  <= in_port;
            r_s1_reg   <= in_reg;
            r_s1_wd    <= s_axis_tdata[PW-1:0];
            r_s1_lv    <= s_axis_tdata[DATA_W+PW-1:DATA_W];
            r_fwd_data <= ram_wr_data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_rd  <= s1_rd;
            r_out_irq <= e_irq_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_irq, r_out_rd};

endmodule

FILE: src/gpioei_port_ram.sv
// Per-port state memory: direction, output latch and sampled level of each port.
`timescale 1ns / 1ps

module gpioei_port_ram
    import gpioei_pkg::*;
#(
    parameter int DEPTH = 6,
    parameter int AW    = 3,
    parameter int DW    = 96
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0] r_rd_data;

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/gpioei_edge.sv
// Edge-detect enables and sticky status bits of the two interrupt ports.
`timescale 1ns / 1ps

module gpioei_edge
    import gpioei_pkg::*;
#(
    parameter int PW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_edge_ctl     i_ctl,
    input  logic [PW-1:0] i_wdata,
    input  logic [PW-1:0] i_old_lvl,
    input  logic [PW-1:0] i_new_lvl,
    output logic [PW-1:0] o_rise_en,
    output logic [PW-1:0] o_fall_en,
    output logic [PW-1:0] o_rise_stat,
    output logic [PW-1:0] o_fall_stat,
    output logic [NUM_SLOTS-1:0] o_pending,
    output logic          o_irq_next
);

    logic [PW-1:0] r_rise_en   [NUM_SLOTS];
    logic [PW-1:0] r_fall_en   [NUM_SLOTS];
    logic [PW-1:0] r_rise_stat [NUM_SLOTS];
    logic [PW-1:0] r_fall_stat [NUM_SLOTS];
    logic [PW-1:0] n_rise_stat [NUM_SLOTS];
    logic [PW-1:0] n_fall_stat [NUM_SLOTS];

    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            n_rise_stat[s] = r_rise_stat[s];
            n_fall_stat[s] = r_fall_stat[s];
            if (i_ctl.slot == 1'(s)) begin
                if (i_ctl.sample) begin
                    n_rise_stat[s] = r_rise_stat[s] | (~i_old_lvl & i_new_lvl & r_rise_en[s]);
                    n_fall_stat[s] = r_fall_stat[s] | (i_old_lvl & ~i_new_lvl & r_fall_en[s]);
                end else if (i_ctl.int_clr) begin
                    n_rise_stat[s] = r_rise_stat[s] & ~i_wdata;
                    n_fall_stat[s] = r_fall_stat[s] & ~i_wdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_rise_en[s]   <= '0;
                r_fall_en[s]   <= '0;
                r_rise_stat[s] <= '0;
                r_fall_stat[s] <= '0;
            end
        end else begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_rise_stat[s] <= n_rise_stat[s];
                r_fall_stat[s] <= n_fall_stat[s];
                if (i_ctl.slot == 1'(s) && i_ctl.wr_rise_en) begin
                    r_rise_en[s] <= i_wdata;
                end
                if (i_ctl.slot == 1'(s) && i_ctl.wr_fall_en) begin
                    r_fall_en[s] <= i_wdata;
                end
            end
        end
    end

    assign o_rise_en   = r_rise_en[i_ctl.slot];
    assign o_fall_en   = r_fall_en[i_ctl.slot];
    assign o_rise_stat = r_rise_stat[i_ctl.slot];
    assign o_fall_stat = r_fall_stat[i_ctl.slot];

    always_comb begin
        o_irq_next = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            o_pending[s] = |(r_rise_stat[s] | r_fall_stat[s]);
            o_irq_next   = o_irq_next | (|(n_rise_stat[s] | n_fall_stat[s]));
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the GPIO block with edge-detect interrupts.
`timescale 1ns / 1ps

module testbench;
    import gpioei_pkg::*;

    localparam int PORT_COUNT     = 6;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 8;

    // Codes that the block must treat as unknown.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [REG_W-1:0] REG_UNUSED  = 4'd15;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PORT_W-1:0] port;
        logic [REG_W-1:0]  reg_sel;
        logic [DATA_W-1:0] wdata;
        logic [DATA_W-1:0] levels;
    } t_gpio_beat;

    // Same layout as the result tdata: read_data low, irq, then zero padding.
    typedef struct packed {
        logic [6:0]        pad;
        logic              irq;
        logic [DATA_W-1:0] rdata;
    } t_gpio_result;

    typedef struct packed {
        t_gpio_beat   beat;
        logic         typed;
        t_gpio_result result;
    } t_gpio_row;

    typedef enum {RX_FREE, RX_COIN, RX_PHASE, RX_SPARSE} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [31:0] write_data, [63:32] pin_levels
    logic [63:0] s_axis_tdata = '0;
    // [1:0] cmd, [4:2] port, [8:5] reg_sel
    logic [8:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] read_data, [32] irq, [39:33] zero
    logic [39:0] m_axis_tdata;

    // Predicted port state.
    logic [DATA_W-1:0] dir_q     [PORT_COUNT];
    logic [DATA_W-1:0] latch_q   [PORT_COUNT];
    logic [DATA_W-1:0] level_q   [PORT_COUNT];
    logic [DATA_W-1:0] rise_en_q [NUM_SLOTS];
    logic [DATA_W-1:0] fall_en_q [NUM_SLOTS];
    logic [DATA_W-1:0] rise_st_q [NUM_SLOTS];
    logic [DATA_W-1:0] fall_st_q [NUM_SLOTS];

    t_gpio_result expected_q[$];
    t_gpio_row    directed_q[$];

    int errors = 0;
    int n_sent = 0, n_effective = 0, n_checked = 0, n_irq_high = 0;
    int n_reads = 0, n_writes = 0, n_samples = 0, n_unknown = 0;
    int burst_left = 0;

    // Receiver control: the sender asks for a long hold-off by bumping the request count.
    int       hold_req_cnt = 0, hold_done_cnt = 0, hold_left = 0, n_holds = 0;
    t_rx_mode rx_mode = RX_FREE;
    int       rx_mode_left = 0, rx_phase = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    gpio_port_with_edge_interrupts #(
        .NUM_PORTS (PORT_COUNT),
        .PORT_WIDTH(DATA_W)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    function automatic t_gpio_beat make_beat(input logic [CMD_W-1:0] cmd,
                                             input logic [PORT_W-1:0] port,
                                             input logic [REG_W-1:0] reg_sel,
                                             input logic [DATA_W-1:0] wdata,
                                             input logic [DATA_W-1:0] levels);
        t_gpio_beat b;
        b.cmd     = cmd;
        b.port    = port;
        b.reg_sel = reg_sel;
        b.wdata   = wdata;
        b.levels  = levels;
        return b;
    endfunction

    function automatic t_gpio_row row(input logic [CMD_W-1:0] cmd,
                                      input logic [PORT_W-1:0] port,
                                      input logic [REG_W-1:0] reg_sel,
                                      input logic [DATA_W-1:0] wdata,
                                      input logic [DATA_W-1:0] levels,
                                      input logic typed,
                                      input logic [DATA_W-1:0] rdata,
                                      input logic irq);
        t_gpio_row r;
        r.beat         = make_beat(cmd, port, reg_sel, wdata, levels);
        r.typed        = typed;
        r.result.pad   = '0;
        r.result.irq   = irq;
        r.result.rdata = rdata;
        return r;
    endfunction

    // Applies one beat to the predicted state and returns the result it should produce.
    task automatic predict_gpio(input t_gpio_beat b, output t_gpio_result r);
        logic              in_range;
        logic              has_edge;
        int                slot;
        int                p;
        logic [DATA_W-1:0] old_lv;
        in_range = (b.port < PORT_COUNT);
        has_edge = (b.port == EDGE_PORT_A) || (b.port == EDGE_PORT_B);
        slot     = (b.port == EDGE_PORT_B) ? 1 : 0;
        p        = int'(b.port);
        r        = '0;
        case (b.cmd)
            CMD_READ: begin
                if (b.reg_sel == REG_SUMMARY) begin
                    r.rdata[EDGE_PORT_A] = |(rise_st_q[0] | fall_st_q[0]);
                    r.rdata[EDGE_PORT_B] = |(rise_st_q[1] | fall_st_q[1]);
                end else if (in_range) begin
                    case (b.reg_sel)
                        REG_DIR: r.rdata = dir_q[p];
                        REG_SET: r.rdata = latch_q[p];
                        REG_PIN: r.rdata = (latch_q[p] & dir_q[p]) | (level_q[p] & ~dir_q[p]);
                        REG_RISE_EN:   if (has_edge) r.rdata = rise_en_q[slot];
                        REG_FALL_EN:   if (has_edge) r.rdata = fall_en_q[slot];
                        REG_RISE_STAT: if (has_edge) r.rdata = rise_st_q[slot];
                        REG_FALL_STAT: if (has_edge) r.rdata = fall_st_q[slot];
                        default: r.rdata = '0;
                    endcase
                end
            end
            CMD_WRITE: begin
                if (in_range) begin
                    case (b.reg_sel)
                        REG_DIR: dir_q[p] = b.wdata;
                        REG_SET: latch_q[p] = latch_q[p] | b.wdata;
                        REG_CLR: latch_q[p] = latch_q[p] & ~b.wdata;
                        REG_PIN: latch_q[p] = b.wdata;
                        REG_RISE_EN: if (has_edge) rise_en_q[slot] = b.wdata;
                        REG_FALL_EN: if (has_edge) fall_en_q[slot] = b.wdata;
                        REG_INT_CLR: begin
                            if (has_edge) begin
                                rise_st_q[slot] = rise_st_q[slot] & ~b.wdata;
                                fall_st_q[slot] = fall_st_q[slot] & ~b.wdata;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_SAMPLE: begin
                if (in_range) begin
                    old_lv     = level_q[p];
                    level_q[p] = b.levels;
                    if (has_edge) begin
                        rise_st_q[slot] = rise_st_q[slot] | (~old_lv & b.levels & rise_en_q[slot]);
                        fall_st_q[slot] = fall_st_q[slot] | (old_lv & ~b.levels & fall_en_q[slot]);
                    end
                end
            end
            default: ;
        endcase
        r.irq = |(rise_st_q[0] | fall_st_q[0] | rise_st_q[1] | fall_st_q[1]);
    endtask

    // Offers one beat and waits for the handshake; the expectation is queued at acceptance.
    task automatic send_beat(input t_gpio_beat b, input logic typed,
                             input t_gpio_result typed_result);
        t_gpio_result want;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.levels, b.wdata};
        s_axis_tuser  <= {b.reg_sel, b.port, b.cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_gpio(b, want);
        if (typed) want = typed_result;
        expected_q.push_back(want);
        n_sent++;
        if (b.cmd != CMD_UNKNOWN &&
            (b.port < PORT_COUNT || (b.cmd == CMD_READ && b.reg_sel == REG_SUMMARY)))
            n_effective++;
        case (b.cmd)
            CMD_READ:   n_reads++;
            CMD_WRITE:  n_writes++;
            CMD_SAMPLE: n_samples++;
            default:    n_unknown++;
        endcase
    endtask

    // Bursts of random length, separated by random gaps (sometimes none).
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        if (expected_q.size() != 0) begin
            s_axis_tvalid <= 1'b0;
            while (expected_q.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Receiver: changes its stall pattern every so often, and honors hold-off requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req_cnt != hold_done_cnt) begin
            m_axis_tready <= 1'b0;
            hold_done_cnt <= hold_req_cnt;
            hold_left     <= HOLD_CYCLES;
            n_holds       <= n_holds + 1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= t_rx_mode'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(16, 200);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            rx_phase <= rx_phase + 1;
            case (rx_mode)
                RX_FREE:  m_axis_tready <= 1'b1;
                RX_COIN:  m_axis_tready <= ($urandom_range(0, 1) == 1);
                RX_PHASE: m_axis_tready <= (rx_phase % 3) != 0;
                default:  m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Result checker: every accepted result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_gpio_result got;
            t_gpio_result want;
            got = m_axis_tdata;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
            end else begin
                want = expected_q.pop_front();
                n_checked++;
                if (got.irq === 1'b1) n_irq_high++;
                check_field("read_data", want.rdata, got.rdata);
                check_field("irq", DATA_W'(want.irq), DATA_W'(got.irq));
                check_field("padding", DATA_W'(want.pad), DATA_W'(got.pad));
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (!i_rst_n) @(posedge i_clk);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no beat moved for %0d cycles, %0d results outstanding",
                 $time, quiet, expected_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_gpio_beat        pending_q[$];
        t_gpio_beat        b;
        logic [PORT_W-1:0] ep;
        logic [CMD_W-1:0]  c;
        logic [PORT_W-1:0] p;
        logic [REG_W-1:0]  rs;
        logic [DATA_W-1:0] wd;
        logic [DATA_W-1:0] lv;
        int                pick;
        int                n_random;

        for (int i = 0; i < PORT_COUNT; i++) begin
            dir_q[i]   = '0;
            latch_q[i] = '0;
            level_q[i] = '0;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            rise_en_q[i] = '0;
            fall_en_q[i] = '0;
            rise_st_q[i] = '0;
            fall_st_q[i] = '0;
        end

        // Directed rows: reset values, extremes, masks, edges and the ignored cases.
        directed_q.push_back(row(CMD_READ, 3'd0, REG_DIR, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_READ, 3'd5, REG_SUMMARY, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_WRITE, 3'd1, REG_DIR, 32'hFFFF_FFFF, 32'h0,
                                 1'b1, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_WRITE, 3'd1, REG_SET, 32'h8000_0001, 32'hFFFF_FFFF,
                                 1'b1, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_READ, 3'd1, REG_SET, 32'h0, 32'h0,
                                 1'b1, 32'h8000_0001, 1'b0));
        directed_q.push_back(row(CMD_WRITE, 3'd1, REG_CLR, 32'h0000_0001, 32'h0,
                                 1'b1, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_READ, 3'd1, REG_PIN, 32'h0, 32'hFFFF_FFFF,
                                 1'b0, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_WRITE, 3'd5, REG_PIN, 32'hFFFF_FFFF, 32'h0,
                                 1'b1, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_SAMPLE, 3'd5, REG_DIR, 32'hFFFF_FFFF, 32'h1234_5678,
                                 1'b1, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_READ, 3'd5, REG_PIN, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_WRITE, 3'd0, REG_RISE_EN, 32'hFFFF_FFFF, 32'h0,
                                 1'b1, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_WRITE, 3'd0, REG_FALL_EN, 32'hFFFF_FFFF, 32'h0,
                                 1'b1, 32'h0, 1'b0));
        // Every pin of port 0 rises at once, so the interrupt line must go high.
        directed_q.push_back(row(CMD_SAMPLE, 3'd0, REG_DIR, 32'h0, 32'hFFFF_FFFF,
                                 1'b1, 32'h0, 1'b1));
        directed_q.push_back(row(CMD_READ, 3'd0, REG_RISE_STAT, 32'h0, 32'h0,
                                 1'b0, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_SAMPLE, 3'd0, REG_DIR, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_READ, 3'd0, REG_FALL_STAT, 32'h0, 32'h0,
                                 1'b0, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_READ, 3'd7, REG_SUMMARY, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
        // A port without edge logic ignores its interrupt registers.
        directed_q.push_back(row(CMD_WRITE, 3'd3, REG_RISE_EN, 32'hFFFF_FFFF, 32'h0,
                                 1'b0, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_READ, 3'd3, REG_RISE_EN, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1));
        // Out-of-range ports, an unused register and an unknown command.
        directed_q.push_back(row(CMD_WRITE, 3'd6, REG_DIR, 32'hFFFF_FFFF, 32'h0,
                                 1'b0, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_READ, 3'd7, REG_DIR, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1));
        directed_q.push_back(row(CMD_READ, 3'd0, REG_UNUSED, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1));
        directed_q.push_back(row(CMD_UNKNOWN, 3'd0, REG_PIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 1'b1, 32'h0, 1'b1));
        directed_q.push_back(row(CMD_WRITE, 3'd0, REG_INT_CLR, 32'hFFFF_FFFF, 32'h0,
                                 1'b1, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_WRITE, 3'd2, REG_RISE_EN, 32'h0000_0001, 32'h0,
                                 1'b0, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_SAMPLE, 3'd2, REG_DIR, 32'h0, 32'h0000_0001,
                                 1'b1, 32'h0, 1'b1));
        directed_q.push_back(row(CMD_READ, 3'd2, REG_SUMMARY, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0));
        directed_q.push_back(row(CMD_READ, 3'd2, REG_INT_CLR, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[i]) begin
            pace_sender();
            send_beat(directed_q[i].beat, directed_q[i].typed, directed_q[i].result);
        end

        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            if (pending_q.size() == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    // Well-formed edge sequence: enable, toggle pins, read status and summary, clear, read pins.
                    ep = ($urandom_range(0, 1) == 1) ? EDGE_PORT_B : EDGE_PORT_A;
                    lv = level_q[ep];
                    pending_q.push_back(make_beat(CMD_WRITE, ep, REG_RISE_EN, $urandom(),
                                                  $urandom()));
                    pending_q.push_back(make_beat(CMD_WRITE, ep, REG_FALL_EN, $urandom(),
                                                  $urandom()));
                    repeat ($urandom_range(1, 4)) begin
                        lv = lv ^ (32'h1 << $urandom_range(0, 31));
                        if ($urandom_range(0, 3) == 0) lv = lv ^ $urandom();
                        pending_q.push_back(make_beat(CMD_SAMPLE, ep, REG_DIR, $urandom(), lv));
                    end
                    pending_q.push_back(make_beat(CMD_READ, ep, REG_RISE_STAT, $urandom(),
                                                  $urandom()));
                    pending_q.push_back(make_beat(CMD_READ, ep, REG_FALL_STAT, $urandom(),
                                                  $urandom()));
                    pending_q.push_back(make_beat(CMD_READ, PORT_W'($urandom_range(0, 7)),
                                                  REG_SUMMARY, $urandom(), $urandom()));
                    pending_q.push_back(make_beat(CMD_WRITE, ep, REG_INT_CLR,
                                                  $urandom() | $urandom(), $urandom()));
                    pending_q.push_back(make_beat(CMD_READ, ep, REG_PIN, $urandom(),
                                                  $urandom()));
                end else begin
                    // Single beat with weighted fields; a few percent fall outside the map.
                    pick = $urandom_range(0, 99);
                    c = (pick < 40) ? CMD_READ : (pick < 75) ? CMD_WRITE :
                        (pick < 97) ? CMD_SAMPLE : CMD_UNKNOWN;
                    pick = $urandom_range(0, 99);
                    p = (pick < 30) ? EDGE_PORT_A : (pick < 55) ? EDGE_PORT_B :
                        (pick < 93) ? PORT_W'($urandom_range(0, PORT_COUNT - 1)) :
                                      PORT_W'($urandom_range(PORT_COUNT, 7));
                    rs = ($urandom_range(0, 99) < 94) ?
                         REG_W'($urandom_range(REG_DIR, REG_SUMMARY)) :
                         REG_W'($urandom_range(REG_SUMMARY + 1, REG_UNUSED));
                    pick = $urandom_range(0, 99);
                    wd = (pick < 10) ? '1 : (pick < 15) ? '0 :
                         (pick < 30) ? (32'h1 << $urandom_range(0, 31)) : $urandom();
                    if (p < PORT_COUNT && $urandom_range(0, 1) == 1)
                        lv = level_q[p] ^ (32'h1 << $urandom_range(0, 31));
                    else
                        lv = $urandom();
                    pending_q.push_back(make_beat(c, p, rs, wd, lv));
                end
            end

            b = pending_q.pop_front();
            pace_sender();
            pick = n_effective;
            send_beat(b, 1'b0, '0);
            if (n_effective != pick) n_random++;

            // Long receiver hold-off while the sender keeps offering beats.
            if (n_random == 350 || n_random == 750) begin
                if (n_effective != pick) begin
                    hold_req_cnt <= hold_req_cnt + 1;
                    burst_left = 80;
                end
            end
            // Sender pauses until every outstanding result has come back.
            if ((n_random == 550 || n_random == 950) && n_effective != pick)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d beats: %0d reads, %0d writes, %0d pin samples, %0d unknown",
                 n_sent, n_reads, n_writes, n_samples, n_unknown);
        $display("%0d results checked, %0d with irq high, %0d receiver hold-offs, %0d errors",
                 n_checked, n_irq_high, n_holds, errors);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
